[sv/stbs_pkg.sv]
// Shared widths, codes and defaults for the sorted table binary search block.
package stbs_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int COUNT_W         = 11;
    localparam int INDEX_W         = 10;
    localparam int DATA_W          = 32;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

endpackage

[sv/stbs_req_if.sv]
// Request channel carrying load and search items.
interface stbs_req_if import stbs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_cmd                     cmd;
    logic [INDEX_W-1:0]       entry_index;
    logic signed [DATA_W-1:0] data_value;

    modport source (output valid, output cmd, output entry_index, output data_value,
                    input ready);
    modport sink   (input valid, input cmd, input entry_index, input data_value,
                    output ready);
endinterface

[sv/stbs_rsp_if.sv]
// Response channel carrying search results.
interface stbs_rsp_if import stbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [INDEX_W-1:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

[sv/stbs_cfg_if.sv]
// Configuration write channel for the entry count register.
interface stbs_cfg_if import stbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/sorted_table_binary_search.sv]
// Sorted table with iterative binary search over a single-port registered memory.
//
//   channel  | dir | payload                              | request accepted when
//   ---------+-----+--------------------------------------+----------------------
//   i_req    | in  | cmd, entry_index, data_value         | valid and ready high
//   o_rsp    | out | found, position                      | valid and ready high
//   i_cfg    | in  | data (entry_count)                   | valid and ready high
//
// A load request writes the table entry and leaves the block ready for the next request.
// A search over n entries makes at most floor(log2(n)) + 1 probes; each probe is one
// registered memory read followed by one compare step. A found key ends the search
// at the compare, and a missing key ends it at an empty-range check before the next read.
// Reset clears the entry count and the control state; the table holds no reset value.
// A finished result waits in the output register while new requests are accepted; a
// second search result waits in its final state until that register is free.
module sorted_table_binary_search import stbs_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stbs_req_if.sink    i_req,
    stbs_rsp_if.source  o_rsp,
    stbs_cfg_if.sink    i_cfg
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADDR = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [COUNT_W-1:0]       r_entry_count;
    logic [CW-1:0]            r_low, n_low;
    logic [CW-1:0]            r_hi, n_hi;
    logic [AW-1:0]            r_mid, n_mid;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic signed [DATA_W-1:0] r_rdata;
    logic                     r_found, n_found;
    logic                     r_out_valid;
    logic                     r_out_found;
    logic [INDEX_W-1:0]       r_out_position;
    logic [DATA_W-1:0]        mem [TABLE_DEPTH];

    logic                     w_req_acc;
    logic                     w_out_free;
    logic [31:0]              w_cnt32;
    logic [CW-1:0]            w_count;
    logic [31:0]              w_idx32;
    logic                     w_idx_ok;
    logic [AW-1:0]            w_waddr;
    logic [CW:0]              w_sum;
    logic [CW:0]              w_half;
    logic [AW-1:0]            w_mid;
    logic [31:0]              w_mid32;
    logic                     w_load;

    assign w_req_acc  = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready    = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.found    = r_out_found;
    assign o_rsp.position = r_out_position;

    assign w_cnt32 = 32'(r_entry_count);
    assign w_count = (w_cnt32 > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(w_cnt32);

    assign w_idx32  = 32'(i_req.entry_index);
    assign w_idx_ok = (w_idx32 < 32'(TABLE_DEPTH));
    assign w_waddr  = w_idx32[AW-1:0];
    assign w_load   = w_req_acc && (i_req.cmd == CMD_LOAD) && w_idx_ok;

    assign w_sum   = {1'b0, r_low} + {1'b0, r_hi} - (CW+1)'(1);
    assign w_half  = w_sum >> 1;
    assign w_mid   = w_half[AW-1:0];
    assign w_mid32 = 32'(r_mid);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            mem[w_waddr] <= i_req.data_value;
        end
        if (r_state == S_ADDR) begin
            r_rdata <= mem[w_mid];
        end
    end

    always_comb begin
        n_state = r_state;
        n_low   = r_low;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_key   = r_key;
        n_found = r_found;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc && i_req.cmd == CMD_SEARCH) begin
                    n_low   = '0;
                    n_hi    = w_count;
                    n_key   = i_req.data_value;
                    n_found = 1'b0;
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                if (r_low >= r_hi) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_mid   = w_mid;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_key == r_rdata) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else begin
                    if (r_key < r_rdata) begin
                        n_hi = CW'(r_mid);
                    end else begin
                        n_low = CW'(r_mid) + CW'(1);
                    end
                    n_state = S_ADDR;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_entry_count <= i_cfg.data;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_low   <= n_low;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_found <= n_found;
        if (r_state == S_DONE && w_out_free) begin
            r_out_found    <= r_found;
            r_out_position <= r_found ? w_mid32[INDEX_W-1:0] : '0;
        end
    end

endmodule

[tb/tb_sorted_table_binary_search.sv]
// Self-checking testbench for the sorted table binary search block with a scoreboard class.
module tb_sorted_table_binary_search import stbs_pkg::*; ();

    localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 150;
    localparam int QUIET_LIMIT   = 2000;

    localparam int FILL_SPREAD   = 0;
    localparam int FILL_DUPS     = 1;
    localparam int FILL_EDGE     = 2;
    localparam int FILL_UNSORTED = 3;

    class search_scoreboard;
        typedef struct packed {
            logic               found;
            logic [INDEX_W-1:0] position;
        } t_hit;

        logic signed [DATA_W-1:0] entries [DEF_TABLE_DEPTH];
        logic [COUNT_W-1:0]       entry_count;
        t_hit                     expected_hits [$];
        int                       errors;
        int                       searches;
        int                       hits;

        function new();
            entry_count = '0;
            errors      = 0;
            searches    = 0;
            hits        = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] value);
            entry_count = value;
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        function t_hit bisect(logic signed [DATA_W-1:0] key);
            int   lo;
            int   hi;
            int   mid;
            t_hit hit;
            hit = '0;
            lo  = 0;
            hi  = (entry_count > DEF_TABLE_DEPTH ? DEF_TABLE_DEPTH : int'(entry_count)) - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (key == entries[mid]) begin
                    hit.found    = 1'b1;
                    hit.position = mid[INDEX_W-1:0];
                    break;
                end
                if (key < entries[mid]) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
            return hit;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task note_request(t_cmd cmd, logic [INDEX_W-1:0] idx, logic signed [DATA_W-1:0] value);
            if (cmd == CMD_LOAD) begin
                entries[idx] = value;
            end else begin
                expected_hits.push_back(bisect(value));
            end
        endtask

        task check_result(logic found, logic [INDEX_W-1:0] position);
            t_hit want;
            if (expected_hits.size() == 0) begin
                report("search result arrived with no search outstanding");
                return;
            end
            want = expected_hits.pop_front();
            searches++;
            if (want.found) begin
                hits++;
            end
            if (found !== want.found) begin
                report($sformatf("search %0d: found %b, expected %b", searches, found, want.found));
            end
            if (position !== want.position) begin
                report($sformatf("search %0d: position %0d, expected %0d",
                                 searches, position, want.position));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    stbs_req_if req_if ();
    stbs_rsp_if rsp_if ();
    stbs_cfg_if cfg_if ();

    sorted_table_binary_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    search_scoreboard         sb = new();
    logic signed [DATA_W-1:0] shadow [DEF_TABLE_DEPTH];
    bit                       idle_on  = 1'b1;
    bit                       hold_rsp = 1'b0;
    int                       loads_sent = 0;
    int                       searches_sent = 0;
    int                       cfg_writes = 0;

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                sb.note_request(req_if.cmd, req_if.entry_index, req_if.data_value);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_result(rsp_if.found, rsp_if.position);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(negedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no request moved for %0d cycles.", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : rsp_sink
        int stall;
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_rsp) begin
                stall    = HOLD_CYCLES;
                hold_rsp = 1'b0;
            end else begin
                stall = idle_on ? $urandom_range(0, 4) : 0;
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(negedge i_clk); while (!rsp_if.valid);
            @(posedge i_clk);
        end
    end

    task automatic send_req(t_cmd cmd, logic [INDEX_W-1:0] idx, logic signed [DATA_W-1:0] value);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.cmd         <= cmd;
        req_if.entry_index <= idx;
        req_if.data_value  <= value;
        do @(negedge i_clk); while (!req_if.ready);
        @(posedge i_clk);
    endtask

    task automatic send_load(logic [INDEX_W-1:0] idx, logic signed [DATA_W-1:0] value);
        shadow[idx] = value;
        loads_sent++;
        send_req(CMD_LOAD, idx, value);
    endtask

    task automatic send_search(logic signed [DATA_W-1:0] key);
        send_req(CMD_SEARCH, INDEX_W'($urandom), key);
        searches_sent++;
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.searches < searches_sent) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_count(logic [COUNT_W-1:0] value);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(negedge i_clk); while (!cfg_if.ready);
        @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        sb.set_count(value);
        cfg_writes++;
    endtask

    task automatic fill_table(int n, int mode);
        int vals [$];
        int order [$];
        int j;
        int tmp;
        for (int i = 0; i < n; i++) begin
            if (mode == FILL_DUPS) begin
                vals.push_back(int'($urandom_range(0, 15)) - 8);
            end else begin
                vals.push_back(int'($urandom));
            end
            order.push_back(i);
        end
        if (mode != FILL_UNSORTED) begin
            vals.sort();
        end
        if (mode == FILL_EDGE && n >= 2) begin
            vals[0]     = KEY_MIN;
            vals[n - 1] = KEY_MAX;
        end
        for (int i = n - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < n; k++) begin
            send_load(order[k][INDEX_W-1:0], vals[order[k]]);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_key(int n);
        int pick;
        pick = $urandom_range(0, 9);
        if (n > 0 && pick < 5) begin
            return shadow[$urandom_range(0, n - 1)];
        end
        if (n > 0 && pick == 5) begin
            return shadow[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        end
        if (pick == 6) begin
            return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
        end
        return $urandom;
    endfunction

    task automatic search_burst(int n, int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                // Stray loads land above the searched range when the table has room there.
                send_load((n < DEF_TABLE_DEPTH) ? INDEX_W'($urandom_range(n, DEF_TABLE_DEPTH - 1))
                                                : INDEX_W'($urandom_range(0, DEF_TABLE_DEPTH - 1)),
                          $urandom);
            end else begin
                send_search(pick_key(n));
            end
        end
    endtask

    initial begin : stimulus
        int n;
        int sel;
        req_if.valid       <= 1'b0;
        req_if.cmd         <= CMD_LOAD;
        req_if.entry_index <= '0;
        req_if.data_value  <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.data        <= '0;
        i_rst_n            <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_search(KEY_MIN);
        send_search('0);
        send_load(0, KEY_MIN);
        send_load(1, -1);
        send_load(2, 0);
        send_load(3, KEY_MAX);
        set_count(1);
        send_search(KEY_MIN);
        send_search(KEY_MAX);
        set_count(4);
        send_search(KEY_MAX);
        send_search(-1);
        send_search(0);
        send_search(5);
        send_search(KEY_MIN);
        set_count(3);
        send_search(KEY_MAX);
        for (int i = 0; i < 4; i++) begin
            send_load(INDEX_W'(i), 7);
        end
        set_count(4);
        send_search(7);
        send_search(6);
        set_count(0);
        send_search(7);

        set_count(COUNT_W'(DEF_TABLE_DEPTH));
        fill_table(DEF_TABLE_DEPTH, FILL_EDGE);
        search_burst(DEF_TABLE_DEPTH, 60);
        hold_rsp = 1'b1;
        search_burst(DEF_TABLE_DEPTH, 60);
        set_count(2047);
        search_burst(DEF_TABLE_DEPTH, 40);
        drain();
        search_burst(DEF_TABLE_DEPTH, 20);
        set_count(COUNT_W'(DEF_TABLE_DEPTH + 1));
        search_burst(DEF_TABLE_DEPTH, 30);
        set_count(COUNT_W'(DEF_TABLE_DEPTH - 1));
        search_burst(DEF_TABLE_DEPTH - 1, 30);

        for (int p = 0; p < 22; p++) begin
            sel = $urandom_range(0, 3);
            case (sel)
                0: begin
                    n = $urandom_range(1, 3);
                end
                1: begin
                    n = $urandom_range(4, 16);
                end
                2: begin
                    n = $urandom_range(17, 64);
                end
                default: begin
                    n = 0;
                end
            endcase
            set_count(COUNT_W'(n));
            idle_on = ($urandom_range(0, 3) != 0);
            fill_table(n, $urandom_range(FILL_SPREAD, FILL_UNSORTED));
            search_burst(n, $urandom_range(10, 24));
        end

        drain();
        $display("Covered %0d table loads and %0d searches (%0d hits)",
                 loads_sent, sb.searches, sb.hits);
        $display("over %0d entry_count writes, tables empty to saturated, sorted, %s",
                 cfg_writes, "duplicate-heavy and unsorted.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
sv/stbs_pkg.sv
sv/stbs_req_if.sv
sv/stbs_rsp_if.sv
sv/stbs_cfg_if.sv
sv/sorted_table_binary_search.sv
tb/tb_sorted_table_binary_search.sv
